### rtl/isort_pkg.sv
`default_nettype none

package isort_pkg;

   localparam int DATA_W = 32;

   // broadcast controls seen by every cell of the chain
   typedef struct packed {
      logic                     insert;
      logic                     shift;
      logic                     descending;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

### rtl/isort_cell.sv
`default_nettype none

module isort_cell (
   input  wire logic                                 clock,
   input  wire isort_pkg::cell_ctrl_type             ctrl,
   input  wire logic                                 occ,
   input  wire logic                                 occ_left,
   input  wire logic                                 ins_left,
   input  wire logic signed [isort_pkg::DATA_W-1:0]  val_left,
   input  wire logic signed [isort_pkg::DATA_W-1:0]  val_right,
   output logic                                      ins,
   output logic signed [isort_pkg::DATA_W-1:0]       val
);

   logic signed [isort_pkg::DATA_W-1:0] val_ff;
   logic signed [isort_pkg::DATA_W-1:0] val_in;
   logic                                goes_first;

   // strict compare keeps equal elements in arrival order
   assign goes_first = ctrl.descending ? (ctrl.value > val_ff) : (ctrl.value < val_ff);
   assign ins        = occ && goes_first;

   always_comb begin
      val_in = val_ff;
      if (ctrl.shift) begin
         val_in = val_right;
      end else if (ctrl.insert && (ins || (!occ && occ_left))) begin
         val_in = ins_left ? val_left : ctrl.value;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val = val_ff;

endmodule

`default_nettype wire

### rtl/insertion_sorter.sv
`default_nettype none

// insertion sorter
// request channel: req_value / req_last_in are taken at a rising edge where
// start is high and busy is low. while a set is loading, one request can be
// taken every cycle: every cell of the chain compares the new value at once
// and the held values move one cell right to open a slot.
// a request with req_last_in set is stored like any other, then busy rises
// and the whole set is emitted from cell 0, one result per cycle, starting
// the cycle after that request. rsp_valid marks each result for exactly one
// cycle; rsp_last_out flags the final one and rsp_dropped is set on every
// result of a set that lost values because the chain was full.
// busy is high while the held values are emitted; the
// next request is taken in the cycle after the last result.
// requests that arrive with the chain full are discarded and remembered for
// the dropped flag; a last request still triggers emission then.
// csr_we writes csr_wdata into the order mode (1 = descending) at once; it
// applies to insertions that follow.
// reset clears the fill count, overflow flag, busy and the mode; the cell
// contents are left as they are and are never read before being written.
// the receiver cannot stall, so results are never held back.
module insertion_sorter #(
   parameter int CAPACITY = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic signed [isort_pkg::DATA_W-1:0]  req_value,
   input  wire logic                                 req_last_in,
   output logic                                      rsp_valid,
   output logic signed [isort_pkg::DATA_W-1:0]       rsp_sorted_value,
   output logic                                      rsp_last_out,
   output logic                                      rsp_dropped,
   input  wire logic                                 csr_we,
   input  wire logic                                 csr_wdata
);

   localparam int FILL_W = $clog2(CAPACITY + 1);

   // control registers
   logic              busy_ff, busy_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              ovf_ff, ovf_in;
   logic              drop_ff, drop_in;
   logic              desc_ff, desc_in;

   logic                         accept;
   logic                         full;
   isort_pkg::cell_ctrl_type     ctrl;

   // chain wiring
   logic [CAPACITY-1:0]                  occ;
   logic [CAPACITY-1:0]                  cell_ins;
   logic signed [isort_pkg::DATA_W-1:0]  cell_val [CAPACITY];

   assign accept = start && !busy_ff;
   assign full   = (fill_ff == FILL_W'(CAPACITY));

   assign ctrl.insert     = accept && !full;
   assign ctrl.shift      = busy_ff;
   assign ctrl.descending = desc_ff;
   assign ctrl.value      = req_value;

   // the chain, one value per cell, cell 0 holds the head of the order
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                                occ_left;
      logic                                ins_left;
      logic signed [isort_pkg::DATA_W-1:0] val_left;
      logic signed [isort_pkg::DATA_W-1:0] val_right;

      assign occ[i] = (fill_ff > FILL_W'(i));

      if (i == 0) begin : g_head
         assign occ_left = 1'b1;
         assign ins_left = 1'b0;
         assign val_left = req_value;
      end else begin : g_body
         assign occ_left = occ[i-1];
         assign ins_left = cell_ins[i-1];
         assign val_left = cell_val[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign val_right = cell_val[i];
      end else begin : g_mid
         assign val_right = cell_val[i+1];
      end

      isort_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occ       (occ[i]),
         .occ_left  (occ_left),
         .ins_left  (ins_left),
         .val_left  (val_left),
         .val_right (val_right),
         .ins       (cell_ins[i]),
         .val       (cell_val[i])
      );
   end

   // fill count doubles as the emission counter
   always_comb begin
      busy_in = busy_ff;
      fill_in = fill_ff;
      ovf_in  = ovf_ff;
      drop_in = drop_ff;
      desc_in = csr_we ? csr_wdata : desc_ff;
      if (busy_ff) begin
         fill_in = fill_ff - FILL_W'(1);
         if (fill_ff == FILL_W'(1)) begin
            busy_in = 1'b0;
         end
      end else if (accept) begin
         if (!full) begin
            fill_in = fill_ff + FILL_W'(1);
         end
         if (req_last_in) begin
            // set done: latch the drop flag for the whole emission
            busy_in = 1'b1;
            drop_in = ovf_ff || full;
            ovf_in  = 1'b0;
         end else if (full) begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fill_ff <= '0;
         ovf_ff  <= 1'b0;
         desc_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fill_ff <= fill_in;
         ovf_ff  <= ovf_in;
         desc_ff <= desc_in;
      end
      drop_ff <= drop_in;
   end

   // outputs from registers; rsp_last_out is decoded from busy and the fill count
   assign busy             = busy_ff;
   assign rsp_valid        = busy_ff;
   assign rsp_sorted_value = cell_val[0];
   assign rsp_last_out     = busy_ff && (fill_ff == FILL_W'(1));
   assign rsp_dropped      = drop_ff;

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(CAPACITY))
      else $error("fill count beyond capacity");

   a_busy_nonempty: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (fill_ff != '0))
      else $error("emitting from an empty chain");

   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff && req_last_in) |=> busy_ff)
      else $error("last request did not start emission");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_last_out |=> (!busy_ff && fill_ff == '0))
      else $error("emission did not end after final result");

endmodule

`default_nettype wire
